@@ hw/rtl/pst_pkg.sv @@
package pst_pkg;

	// Field widths fixed by the interface
	localparam int DATA_W          = 32;
	localparam int CMD_W           = 2;
	localparam int STATUS_W        = 2;
	localparam int SLOT_W          = 4;
	localparam int COUNT_W         = 5;
	localparam int ENTRY_COUNT_DEF = 16;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_ADD        = 2'd0,
		CMD_REMOVE     = 2'd1,
		CMD_FIND_OWNER = 2'd2,
		CMD_FIND_ID    = 2'd3
	} cmd_t;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

	// Strobes from the sequencer to the slot store
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_en;
	} store_ctl_t;

	// Result of the shared comparator
	typedef struct packed {
		logic eq;
		logic gt;
	} cmp_res_t;

endpackage

@@ hw/rtl/pst_cmp.sv @@
module pst_cmp
	import pst_pkg::*;
(
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	output cmp_res_t          res
);

	// Single unsigned comparator shared by key match and max tracking
	assign res.eq = (a == b);
	assign res.gt = (a > b);

endmodule

@@ hw/rtl/pst_store.sv @@
module pst_store
	import pst_pkg::*;
#(
	parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
	localparam int AW = $clog2(ENTRY_COUNT)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  store_ctl_t        ctl,
	input  logic [AW-1:0]     rd_addr,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_id,
	input  logic [DATA_W-1:0] wr_owner,
	output logic [DATA_W-1:0] rd_id,
	output logic [DATA_W-1:0] rd_owner,
	output logic              rd_act
);

	logic [2*DATA_W-1:0] mem_q [ENTRY_COUNT];
	logic [2*DATA_W-1:0] rd_data_q;
	logic [ENTRY_COUNT-1:0] act_q;
	logic rd_act_q;

	// Slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= {wr_owner, wr_id};
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Active marks, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= '0;
			rd_act_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				act_q[wr_addr] <= 1'b1;
			end else if (ctl.clr_en) begin
				act_q[wr_addr] <= 1'b0;
			end
			if (ctl.rd_en) begin
				rd_act_q <= act_q[rd_addr];
			end
		end
	end

	assign rd_id    = rd_data_q[DATA_W-1:0];
	assign rd_owner = rd_data_q[2*DATA_W-1:DATA_W];
	assign rd_act   = rd_act_q;

`ifndef SYNTHESIS
	a_wr_sets_act: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |=> act_q[$past(wr_addr)])
		else $error("slot not marked active after write");

	a_clr_drops_act: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.clr_en && !ctl.wr_en) |=> !act_q[$past(wr_addr)])
		else $error("slot still active after clear");

	a_rd_act_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.rd_en && !ctl.wr_en && !ctl.clr_en) |=> rd_act_q == $past(act_q[rd_addr]))
		else $error("read active mark does not match slot");
`endif

endmodule

@@ hw/rtl/partition_slot_table_unit.sv @@
// Channel   Direction  Transfer when             Payload
// request   in         req_valid && !req_stall   command, owner_key, id_key
// response  out        rsp_valid && !rsp_stall   status, slot_index, result_id,
//                                                result_owner, count_now
//
// A command scans every slot between transfer and result:
// the slot memory's single read port walks one slot per cycle, the last slot read is then
// compared, and the finish state settles the result and the table update.
// The next command is taken once the unit is back in its idle state.
// Reset clears the active marks and the live count at once; no clearing pass.
// A stalled result holds in its output register; a finished command waits for it.
module partition_slot_table_unit
	import pst_pkg::*;
#(
	parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [CMD_W-1:0]    command,
	input  logic [DATA_W-1:0]   owner_key,
	input  logic [DATA_W-1:0]   id_key,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   slot_index,
	output logic [DATA_W-1:0]   result_id,
	output logic [DATA_W-1:0]   result_owner,
	output logic [COUNT_W-1:0]  count_now
);

	localparam int AW = $clog2(ENTRY_COUNT);
	localparam int CW = $clog2(ENTRY_COUNT + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	logic [DATA_W-1:0] owner_q, id_q;
	logic [CW-1:0] scan_q;
	logic [CW-1:0] count_q, count_nxt;
	logic rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic hit_q;
	logic [AW-1:0] slot_q;
	logic [DATA_W-1:0] max_q, rid_q, rown_q;
	logic issue, fin_go;
	store_ctl_t ctl;
	logic [DATA_W-1:0] rd_id, rd_owner, cmp_a, cmp_b, new_id;
	logic rd_act;
	cmp_res_t cmp;

	logic rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0] slot_index_q;
	logic [DATA_W-1:0] result_id_q, result_owner_q;
	logic [COUNT_W-1:0] count_now_q;

	// Scan issue and finish handshake
	assign issue  = (state_q == S_SCAN) && (scan_q != CW'(ENTRY_COUNT));
	assign fin_go = (state_q == S_FIN) && (!rsp_valid_q || !rsp_stall);
	assign new_id = max_q + DATA_W'(1);

	always_comb begin
		ctl.rd_en  = issue;
		ctl.wr_en  = fin_go && hit_q && (cmd_q == CMD_ADD);
		ctl.clr_en = fin_go && hit_q && (cmd_q == CMD_REMOVE);
	end

	pst_store #(
		.ENTRY_COUNT(ENTRY_COUNT)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rd_addr  (scan_q[AW-1:0]),
		.wr_addr  (slot_q),
		.wr_id    (new_id),
		.wr_owner (owner_q),
		.rd_id    (rd_id),
		.rd_owner (rd_owner),
		.rd_act   (rd_act)
	);

	// Shared comparator: max tracking on add, key match otherwise
	always_comb begin
		cmp_a = (cmd_q == CMD_FIND_OWNER) ? rd_owner : rd_id;
		unique case (cmd_q)
			CMD_ADD:        cmp_b = max_q;
			CMD_FIND_OWNER: cmp_b = owner_q;
			default:        cmp_b = id_q;
		endcase
	end

	pst_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp)
	);

	// Live count after the command
	always_comb begin
		count_nxt = count_q;
		if (hit_q && cmd_q == CMD_ADD) begin
			count_nxt = count_q + CW'(1);
		end else if (hit_q && cmd_q == CMD_REMOVE && count_q != '0) begin
			count_nxt = count_q - CW'(1);
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_q      <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			// Result valid: raised on finish, dropped once transferred
			if (fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						scan_q  <= '0;
						hit_q   <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + CW'(1);
					end else begin
						state_q <= S_FIN;
					end
					if (rd_vld_s1 && !hit_q) begin
						if (cmd_q == CMD_ADD) begin
							hit_q <= !rd_act;
						end else begin
							hit_q <= rd_act && cmp.eq;
						end
					end
				end
				S_FIN: begin
					if (fin_go) begin
						count_q <= count_nxt;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command capture and scan payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			cmd_q   <= cmd_t'(command);
			owner_q <= owner_key;
			id_q    <= id_key;
			max_q   <= '0;
		end
		if (state_q == S_SCAN && rd_vld_s1) begin
			if (cmd_q == CMD_ADD) begin
				if (rd_act && cmp.gt) begin
					max_q <= rd_id;
				end
				if (!rd_act && !hit_q) begin
					slot_q <= rd_idx_s1;
				end
			end else if (rd_act && cmp.eq && !hit_q) begin
				slot_q <= rd_idx_s1;
				rid_q  <= rd_id;
				rown_q <= rd_owner;
			end
		end
		if (issue) begin
			rd_idx_s1 <= scan_q[AW-1:0];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (fin_go) begin
			count_now_q <= COUNT_W'(count_nxt);
			if (!hit_q) begin
				status_q       <= (cmd_q == CMD_ADD) ? ST_FULL : ST_NONE;
				slot_index_q   <= '0;
				result_id_q    <= '0;
				result_owner_q <= '0;
			end else begin
				status_q     <= ST_OK;
				slot_index_q <= SLOT_W'(slot_q);
				if (cmd_q == CMD_ADD) begin
					result_id_q    <= new_id;
					result_owner_q <= owner_q;
				end else begin
					result_id_q    <= rid_q;
					result_owner_q <= rown_q;
				end
			end
		end
	end

	assign req_stall    = (state_q != S_IDLE);
	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign slot_index   = slot_index_q;
	assign result_id    = result_id_q;
	assign result_owner = result_owner_q;
	assign count_now    = count_now_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRY_COUNT))
		else $error("live count above table size");

	a_count_only_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_FIN) |=> $stable(count_q))
		else $error("live count changed outside finish");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q != ST_OK) |->
		(slot_index_q == '0 && result_id_q == '0 && result_owner_q == '0))
		else $error("failed command carries a non-zero payload");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FIN))
		else $error("result raised outside finish");
`endif

endmodule

@@ verif/partition_slot_table_checker.sv @@
// Watches both channels of the slot table, keeps its own copy of the table,
// works out the reply to every request transfer and compares each response
// transfer with the oldest reply still owed.
module partition_slot_table_checker
	import pst_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  logic [CMD_W-1:0]    command,
	input  logic [DATA_W-1:0]   owner_key,
	input  logic [DATA_W-1:0]   id_key,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  logic [STATUS_W-1:0] status,
	input  logic [SLOT_W-1:0]   slot_index,
	input  logic [DATA_W-1:0]   result_id,
	input  logic [DATA_W-1:0]   result_owner,
	input  logic [COUNT_W-1:0]  count_now,
	output int                  fail_count,
	output int                  pending,
	output int                  results_seen,
	output int                  full_seen,
	output int                  miss_seen,
	output logic [DATA_W-1:0]   top_id
);

	localparam int SLOTS = ENTRY_COUNT_DEF;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [DATA_W-1:0]   id;
		logic [DATA_W-1:0]   owner;
		logic [COUNT_W-1:0]  count;
	} table_reply_t;

	// Shadow copy of the table
	logic [DATA_W-1:0]  slot_id    [SLOTS];
	logic [DATA_W-1:0]  slot_owner [SLOTS];
	logic [SLOTS-1:0]   slot_live = '0;
	logic [COUNT_W-1:0] live_total = '0;

	table_reply_t owed_replies[$];
	int mismatches = 0;
	int n_results  = 0;
	int n_full     = 0;
	int n_miss     = 0;
	int n_owed     = 0;
	logic [DATA_W-1:0] highest_id = '0;

	assign fail_count   = mismatches;
	assign pending      = n_owed;
	assign results_seen = n_results;
	assign full_seen    = n_full;
	assign miss_seen    = n_miss;
	assign top_id       = highest_id;

	// Lowest live slot whose owner or identifier equals the key, -1 if none
	function automatic int lowest_match(input logic by_owner, input logic [DATA_W-1:0] key);
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_live[i] && (by_owner ? slot_owner[i] : slot_id[i]) == key)
				return i;
		end
		return -1;
	endfunction

	function automatic logic [DATA_W-1:0] largest_live_id();
		logic [DATA_W-1:0] m;
		m = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_live[i] && slot_id[i] > m)
				m = slot_id[i];
		end
		return m;
	endfunction

	// Applies one command to the shadow table and returns its reply
	function automatic table_reply_t apply_command(input cmd_t op,
			input logic [DATA_W-1:0] own, input logic [DATA_W-1:0] idk);
		table_reply_t r;
		int s;
		r.status = ST_NONE;
		r.slot   = '0;
		r.id     = '0;
		r.owner  = '0;
		s        = -1;
		case (op)
			CMD_ADD: begin
				// lowest free slot; new id wraps past all ones to zero
				for (int i = 0; i < SLOTS; i++) begin
					if (!slot_live[i] && s < 0)
						s = i;
				end
				if (s < 0) begin
					r.status = ST_FULL;
				end else begin
					slot_id[s]    = largest_live_id() + DATA_W'(1);
					slot_owner[s] = own;
					slot_live[s]  = 1'b1;
					live_total    = live_total + COUNT_W'(1);
					r.status      = ST_OK;
					r.slot        = SLOT_W'(s);
					r.id          = slot_id[s];
					r.owner       = own;
				end
			end
			CMD_REMOVE: begin
				s = lowest_match(1'b0, idk);
				if (s >= 0) begin
					r.status      = ST_OK;
					r.slot        = SLOT_W'(s);
					r.id          = slot_id[s];
					r.owner       = slot_owner[s];
					slot_id[s]    = '0;
					slot_owner[s] = '0;
					slot_live[s]  = 1'b0;
					if (live_total != '0)
						live_total = live_total - COUNT_W'(1);
				end
			end
			default: begin
				s = (op == CMD_FIND_OWNER) ? lowest_match(1'b1, own) : lowest_match(1'b0, idk);
				if (s >= 0) begin
					r.status = ST_OK;
					r.slot   = SLOT_W'(s);
					r.id     = slot_id[s];
					r.owner  = slot_owner[s];
				end
			end
		endcase
		r.count = live_total;
		return r;
	endfunction

	task automatic check_field(input string what, input logic [DATA_W-1:0] want_v,
			input logic [DATA_W-1:0] got_v);
		if (got_v !== want_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
		end
	endtask

	// Response side first, then the request taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		table_reply_t want;
		if (!arst_n) begin
			slot_live  = '0;
			live_total = '0;
			owed_replies.delete();
			n_owed     = 0;
			highest_id = '0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				n_results++;
				if (owed_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: response transfer with no reply owed", $time);
				end else begin
					want = owed_replies.pop_front();
					check_field("status", DATA_W'(want.status), DATA_W'(status));
					check_field("slot_index", DATA_W'(want.slot), DATA_W'(slot_index));
					check_field("result_id", want.id, result_id);
					check_field("result_owner", want.owner, result_owner);
					check_field("count_now", DATA_W'(want.count), DATA_W'(count_now));
					if (want.status == ST_FULL)
						n_full++;
					if (want.status == ST_NONE)
						n_miss++;
				end
			end
			if (req_valid && !req_stall)
				owed_replies.push_back(apply_command(cmd_t'(command), owner_key, id_key));
			n_owed     = owed_replies.size();
			highest_id = largest_live_id();
		end
	end

endmodule

@@ verif/tb.sv @@
module tb;
	import pst_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic [CMD_W-1:0]    command = CMD_ADD;
	logic [DATA_W-1:0]   owner_key = '0;
	logic [DATA_W-1:0]   id_key = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_index;
	logic [DATA_W-1:0]   result_id;
	logic [DATA_W-1:0]   result_owner;
	logic [COUNT_W-1:0]  count_now;

	int                fail_count;
	int                pending;
	int                results_seen;
	int                full_seen;
	int                miss_seen;
	logic [DATA_W-1:0] top_id;

	logic idle_on = 1'b1;
	logic held_long = 1'b0;
	int   stall_left = 0;
	int   n_sent = 0;

	// Small owner set so that finds and duplicates hit often
	logic [DATA_W-1:0] owner_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_5A5A,
		32'hA5A5_A5A5, 32'h0000_0007, 32'h8000_0001};

	partition_slot_table_unit uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.command(command), .owner_key(owner_key), .id_key(id_key),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .slot_index(slot_index), .result_id(result_id),
		.result_owner(result_owner), .count_now(count_now)
	);

	partition_slot_table_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.command(command), .owner_key(owner_key), .id_key(id_key),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .slot_index(slot_index), .result_id(result_id),
		.result_owner(result_owner), .count_now(count_now),
		.fail_count(fail_count), .pending(pending), .results_seen(results_seen),
		.full_seen(full_seen), .miss_seen(miss_seen), .top_id(top_id)
	);

	always #4 clk = ~clk;

	// Run limit
	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Response side: random stall bursts, plus one long hold-off once traffic is flowing
	initial begin
		forever begin
			@(negedge clk);
			if (!held_long && results_seen >= 50) begin
				held_long  = 1'b1;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				rsp_stall = 1'b1;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				rsp_stall  = 1'b1;
				stall_left = $urandom_range(0, 13);
			end else begin
				rsp_stall = 1'b0;
			end
		end
	end

	// One request transfer; called and returns at a falling edge
	task automatic send_cmd(input cmd_t op, input logic [DATA_W-1:0] own,
			input logic [DATA_W-1:0] idk);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		command   = op;
		owner_key = own;
		id_key    = idk;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		n_sent++;
	endtask

	// Mostly keys that hit live entries; the rest is noise
	task automatic send_random(input int w_add, input int w_rem);
		int pick;
		int r;
		cmd_t op;
		logic [DATA_W-1:0] own;
		logic [DATA_W-1:0] idk;
		pick = $urandom_range(0, w_add + w_rem + 3);
		if (pick < w_add)
			op = CMD_ADD;
		else if (pick < w_add + w_rem)
			op = CMD_REMOVE;
		else
			op = $urandom_range(0, 1) ? CMD_FIND_OWNER : CMD_FIND_ID;
		own = ($urandom_range(0, 3) == 0) ? $urandom : owner_pool[$urandom_range(0, 5)];
		r = $urandom_range(0, 9);
		if (r < 7)
			idk = top_id - $urandom_range(0, 17);
		else if (r < 9)
			idk = $urandom;
		else
			idk = $urandom_range(0, 2);
		send_cmd(op, own, idk);
	endtask

	task automatic wait_drained;
		req_valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty table: every lookup and remove misses
		send_cmd(CMD_FIND_OWNER, 32'h0000_0000, 32'hFFFF_FFFF);
		send_cmd(CMD_FIND_ID, 32'hFFFF_FFFF, 32'h0000_0000);
		send_cmd(CMD_REMOVE, 32'h0000_0000, 32'h0000_0001);

		// Fill every slot, with a repeated owner, then overfill
		send_cmd(CMD_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
		send_cmd(CMD_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
		send_cmd(CMD_ADD, 32'h5A5A_5A5A, $urandom);
		send_cmd(CMD_ADD, 32'h5A5A_5A5A, $urandom);
		for (int i = 4; i < ENTRY_COUNT_DEF; i++)
			send_cmd(CMD_ADD, (i == 9) ? 32'hA5A5_A5A5 : 32'h1000_0000 + i, $urandom);
		send_cmd(CMD_ADD, 32'h1234_5678, 32'h0000_0001);

		// Duplicate owner gives the lowest slot; unused keys are ignored
		send_cmd(CMD_FIND_OWNER, 32'h5A5A_5A5A, 32'h0000_0003);
		send_cmd(CMD_FIND_ID, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
		send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0005);
		send_cmd(CMD_REMOVE, 32'h0000_0000, 32'h0000_0010);
		// re-add fills the freed low slot with the largest live id plus one
		send_cmd(CMD_ADD, 32'hC3C3_C3C3, 32'h0000_0005);
		send_cmd(CMD_FIND_ID, $urandom, 32'h0000_0010);
		wait_drained();

		// Random phases: add-heavy, remove-heavy, then balanced twice
		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 3) begin
				@(posedge clk);
				idle_on = 1'b0;
				@(negedge clk);
			end
			for (int k = 0; k < 100; k++) begin
				case (ph)
					0:       send_random(5, 1);
					1:       send_random(1, 5);
					default: send_random(3, 3);
				endcase
			end
			wait_drained();
		end

		repeat (40) @(negedge clk);
		$display("Sent %0d commands through fill, overfill, drain and mixed phases;", n_sent);
		$display("checked %0d replies, %0d of them table full and %0d no match.",
			results_seen, full_seen, miss_seen);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
